[design/iaid_pkg.sv]
`default_nettype none
package iaid_pkg;

    // field widths fixed by the item format
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 5;
    localparam int WORD_W  = 32;
    localparam int HELD_W  = 6;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FETCH  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_PUSH,
        OP_FETCH,
        OP_UPDATE,
        OP_DELETE,
        OP_POP,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic        [MODE_W-1:0]  mode;
        logic        [INDEX_W-1:0] index;
        logic signed [WORD_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] data;
        logic        [HELD_W-1:0] held_count;
        logic                     last;
    } t_result;

    typedef struct packed {
        t_op                       op;
        logic        [INDEX_W-1:0] index;
        logic signed [WORD_W-1:0]  value;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_FETCH
    } t_back_state;

endpackage
`default_nettype wire

[design/indexed_array_insert_delete.sv]
// Input words wait in the front register, then the command queue; result words
// wait in the result queue. Throughput: one input word per cycle for insert,
// push, update, delete and pop while results drain; fetch holds the back stage
// for one result per held word (one if empty). Its parallel shift sets the rate.
// Reset (synchronous, active low) clears the count, queues and control state;
// the cells keep whatever they held, and only written cells are read out.
`default_nettype none
module indexed_array_insert_delete #(
    parameter int DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire iaid_pkg::t_in_item i_item,
    output logic                    empty,
    input  wire logic               pop,
    output iaid_pkg::t_result       o_result
);

    localparam int CMD_W = $bits(iaid_pkg::t_cmd);
    localparam int RES_W = $bits(iaid_pkg::t_result);

    logic              front_wr;
    iaid_pkg::t_cmd    front_cmd;
    logic              cmdq_full;
    logic              cmdq_empty;
    logic [CMD_W-1:0]  cmdq_rdata;
    logic              cmd_pop;
    logic              resq_full;
    logic              res_push;
    iaid_pkg::t_result back_res;
    logic [RES_W-1:0]  resq_rdata;
    logic              res_rd;

    // accept and classify
    iaid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_wr   (front_wr),
        .o_cmd      (front_cmd),
        .i_cmd_full (cmdq_full)
    );

    // decouple front from back
    iaid_fifo #(
        .WIDTH (CMD_W)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_wdata (front_cmd),
        .o_full  (cmdq_full),
        .i_rd    (cmd_pop),
        .o_rdata (cmdq_rdata),
        .o_empty (cmdq_empty)
    );

    // execute against the cell array
    iaid_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmdq_empty),
        .i_cmd       (iaid_pkg::t_cmd'(cmdq_rdata)),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (resq_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // hold results until taken
    assign res_rd = pop && !empty;

    iaid_fifo #(
        .WIDTH (RES_W)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (back_res),
        .o_full  (resq_full),
        .i_rd    (res_rd),
        .o_rdata (resq_rdata),
        .o_empty (empty)
    );

    assign o_result = iaid_pkg::t_result'(resq_rdata);

endmodule
`default_nettype wire

[design/iaid_fifo.sv]
`default_nettype none
module iaid_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rptr];

    // advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (i_rd) begin
                r_rptr <= ~r_rptr;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

[design/iaid_front.sv]
`default_nettype none
module iaid_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire iaid_pkg::t_in_item i_item,
    output logic                   o_full,
    output logic                   o_cmd_wr,
    output iaid_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_full
);

    logic            r_valid;
    iaid_pkg::t_cmd  r_cmd;
    iaid_pkg::t_cmd  n_cmd;
    logic            accept;

    // stall only while the held word cannot move on
    assign o_full   = r_valid && i_cmd_full;
    assign accept   = i_push && !o_full;
    assign o_cmd_wr = r_valid && !i_cmd_full;
    assign o_cmd    = r_cmd;

    // classify the mode code; unused codes become no-ops
    always_comb begin
        n_cmd.index = i_item.index;
        n_cmd.value = i_item.value;
        unique case (i_item.mode)
            iaid_pkg::MODE_INSERT: n_cmd.op = iaid_pkg::OP_INSERT;
            iaid_pkg::MODE_PUSH:   n_cmd.op = iaid_pkg::OP_PUSH;
            iaid_pkg::MODE_FETCH:  n_cmd.op = iaid_pkg::OP_FETCH;
            iaid_pkg::MODE_UPDATE: n_cmd.op = iaid_pkg::OP_UPDATE;
            iaid_pkg::MODE_DELETE: n_cmd.op = iaid_pkg::OP_DELETE;
            iaid_pkg::MODE_POP:    n_cmd.op = iaid_pkg::OP_POP;
            default:               n_cmd.op = iaid_pkg::OP_NOP;
        endcase
    end

    // hold the decoded word until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && i_cmd_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

[design/iaid_back.sv]
`default_nettype none
module iaid_back #(
    parameter int DEPTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_empty,
    input  wire iaid_pkg::t_cmd  i_cmd,
    output logic                 o_cmd_pop,
    input  wire logic            i_res_full,
    output logic                 o_res_push,
    output iaid_pkg::t_result    o_res
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int AW  = $clog2(DEPTH);
    localparam int IXW = (CW > iaid_pkg::INDEX_W) ? CW : iaid_pkg::INDEX_W;

    logic signed [iaid_pkg::WORD_W-1:0] r_cells [DEPTH];
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [AW-1:0]          r_ptr;
    logic [AW-1:0]          n_ptr;
    iaid_pkg::t_back_state  r_state;
    iaid_pkg::t_back_state  n_state;
    iaid_pkg::t_op          wr_op;

    logic go;
    logic is_full;
    logic is_empty;
    logic idx_ok;
    logic fetch_last;

    assign go         = (r_state == iaid_pkg::BK_IDLE) && !i_cmd_empty && !i_res_full;
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign idx_ok     = (IXW'(i_cmd.index) < IXW'(r_count));
    assign fetch_last = (CW'(r_ptr) == (r_count - CW'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iaid_pkg::BK_IDLE: begin
                if (go && (i_cmd.op == iaid_pkg::OP_FETCH) && (r_count > CW'(1))) begin
                    n_state = iaid_pkg::BK_FETCH;
                end
            end
            iaid_pkg::BK_FETCH: begin
                if (!i_res_full && fetch_last) begin
                    n_state = iaid_pkg::BK_IDLE;
                end
            end
            default: n_state = iaid_pkg::BK_IDLE;
        endcase
    end

    // execute the command and build the result word
    always_comb begin
        o_cmd_pop        = 1'b0;
        o_res_push       = 1'b0;
        n_count          = r_count;
        n_ptr            = r_ptr;
        wr_op            = iaid_pkg::OP_NOP;
        o_res.status     = iaid_pkg::ST_OK;
        o_res.data       = '0;
        o_res.last       = 1'b1;
        o_res.held_count = iaid_pkg::HELD_W'(r_count);
        unique case (r_state)
            iaid_pkg::BK_IDLE: begin
                if (go) begin
                    o_cmd_pop  = 1'b1;
                    o_res_push = 1'b1;
                    unique case (i_cmd.op)
                        iaid_pkg::OP_INSERT: begin
                            if (is_full) begin
                                o_res.status = iaid_pkg::ST_FULL;
                            end else if (!idx_ok) begin
                                o_res.status = iaid_pkg::ST_BAD_INDEX;
                            end else begin
                                wr_op   = iaid_pkg::OP_INSERT;
                                n_count = r_count + CW'(1);
                            end
                        end
                        iaid_pkg::OP_PUSH: begin
                            if (is_full) begin
                                o_res.status = iaid_pkg::ST_FULL;
                            end else begin
                                wr_op   = iaid_pkg::OP_PUSH;
                                n_count = r_count + CW'(1);
                            end
                        end
                        iaid_pkg::OP_FETCH: begin
                            if (is_empty) begin
                                o_res.status = iaid_pkg::ST_EMPTY;
                            end else begin
                                o_res.data = r_cells[0];
                                o_res.last = (r_count == CW'(1));
                                n_ptr      = AW'(1);
                            end
                        end
                        iaid_pkg::OP_UPDATE: begin
                            if (!idx_ok) begin
                                o_res.status = iaid_pkg::ST_BAD_INDEX;
                            end else begin
                                wr_op = iaid_pkg::OP_UPDATE;
                            end
                        end
                        iaid_pkg::OP_DELETE: begin
                            if (!idx_ok) begin
                                o_res.status = iaid_pkg::ST_BAD_INDEX;
                            end else begin
                                wr_op   = iaid_pkg::OP_DELETE;
                                n_count = r_count - CW'(1);
                            end
                        end
                        iaid_pkg::OP_POP: begin
                            if (is_empty) begin
                                o_res.status = iaid_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    o_res.held_count = iaid_pkg::HELD_W'(n_count);
                end
            end
            iaid_pkg::BK_FETCH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.data = r_cells[r_ptr];
                    o_res.last = fetch_last;
                    n_ptr      = fetch_last ? '0 : r_ptr + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iaid_pkg::BK_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    // shift, place or overwrite every cell in parallel
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic at_idx;
        logic above_idx;
        logic at_count;

        assign at_idx    = (IXW'(g) == IXW'(i_cmd.index));
        assign above_idx = (IXW'(g) > IXW'(i_cmd.index));
        assign at_count  = (CW'(g) == r_count);

        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                case (wr_op) inside
                    iaid_pkg::OP_INSERT, iaid_pkg::OP_UPDATE: begin
                        if (at_idx) begin
                            r_cells[g] <= i_cmd.value;
                        end
                    end
                    iaid_pkg::OP_PUSH: begin
                        if (at_count) begin
                            r_cells[g] <= i_cmd.value;
                        end
                    end
                    iaid_pkg::OP_DELETE: begin
                        if (at_idx) begin
                            r_cells[g] <= r_cells[g + 1];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (g == DEPTH - 1) begin : g_top
            always_ff @(posedge i_clk) begin
                case (wr_op)
                    iaid_pkg::OP_INSERT: begin
                        if (above_idx) begin
                            r_cells[g] <= r_cells[g - 1];
                        end else if (at_idx) begin
                            r_cells[g] <= i_cmd.value;
                        end
                    end
                    iaid_pkg::OP_UPDATE: begin
                        if (at_idx) begin
                            r_cells[g] <= i_cmd.value;
                        end
                    end
                    iaid_pkg::OP_PUSH: begin
                        if (at_count) begin
                            r_cells[g] <= i_cmd.value;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                case (wr_op)
                    iaid_pkg::OP_INSERT: begin
                        if (above_idx) begin
                            r_cells[g] <= r_cells[g - 1];
                        end else if (at_idx) begin
                            r_cells[g] <= i_cmd.value;
                        end
                    end
                    iaid_pkg::OP_UPDATE: begin
                        if (at_idx) begin
                            r_cells[g] <= i_cmd.value;
                        end
                    end
                    iaid_pkg::OP_PUSH: begin
                        if (at_count) begin
                            r_cells[g] <= i_cmd.value;
                        end
                    end
                    iaid_pkg::OP_DELETE: begin
                        if (above_idx || at_idx) begin
                            r_cells[g] <= r_cells[g + 1];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = 32;
    localparam int RANDOM_WORDS    = 250;
    localparam int QUIET_WORDS     = 40;
    localparam int HOLD_OFF_AT     = 60;
    localparam int DRAIN_AT        = 150;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int REPORT_LIMIT    = 10;

    // mode codes the block must ignore
    localparam logic [iaid_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [iaid_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef enum int {
        PH_GROW,
        PH_MIX,
        PH_SHRINK
    } t_phase;

    // Mirror of the array: predicts result words and checks them in order
    class array_mirror;
        logic signed [iaid_pkg::WORD_W-1:0] cells [DEPTH];
        int unsigned       held;
        iaid_pkg::t_result awaited[$];
        int                mismatches;
        int                words_seen;
        int                results_checked;
        int                full_hits;
        int                peak_held;

        function new();
            held            = 0;
            mismatches      = 0;
            words_seen      = 0;
            results_checked = 0;
            full_hits       = 0;
            peak_held       = 0;
        endfunction

        function void await_result(iaid_pkg::t_status st,
                                   logic signed [iaid_pkg::WORD_W-1:0] data, logic last);
            iaid_pkg::t_result r;
            r.status     = st;
            r.data       = data;
            r.held_count = iaid_pkg::HELD_W'(held);
            r.last       = last;
            awaited.push_back(r);
        endfunction

        // apply one accepted input word and queue what it should produce
        function void note_word(iaid_pkg::t_in_item w);
            iaid_pkg::t_status st;
            int unsigned       i;
            int unsigned       idx;
            st  = iaid_pkg::ST_OK;
            idx = 32'(w.index);
            words_seen++;
            case (w.mode)
                iaid_pkg::MODE_INSERT: begin
                    if (held >= DEPTH) begin
                        st = iaid_pkg::ST_FULL;
                    end else if (idx >= held) begin
                        st = iaid_pkg::ST_BAD_INDEX;
                    end else begin
                        for (i = held; i > idx; i--) cells[i] = cells[i - 1];
                        cells[idx] = w.value;
                        held++;
                    end
                end
                iaid_pkg::MODE_PUSH: begin
                    if (held >= DEPTH) begin
                        st = iaid_pkg::ST_FULL;
                    end else begin
                        cells[held] = w.value;
                        held++;
                    end
                end
                iaid_pkg::MODE_FETCH: begin
                    if (held == 0) begin
                        st = iaid_pkg::ST_EMPTY;
                    end else begin
                        for (i = 0; i < held; i++) begin
                            await_result(iaid_pkg::ST_OK, cells[i], i + 1 == held);
                        end
                        return;
                    end
                end
                iaid_pkg::MODE_UPDATE: begin
                    if (idx >= held) st = iaid_pkg::ST_BAD_INDEX;
                    else cells[idx] = w.value;
                end
                iaid_pkg::MODE_DELETE: begin
                    if (idx >= held) begin
                        st = iaid_pkg::ST_BAD_INDEX;
                    end else begin
                        for (i = idx; i + 1 < held; i++) cells[i] = cells[i + 1];
                        held--;
                    end
                end
                iaid_pkg::MODE_POP: begin
                    if (held == 0) st = iaid_pkg::ST_EMPTY;
                    else held--;
                end
                default: begin
                end
            endcase
            if (st == iaid_pkg::ST_FULL) full_hits++;
            if (held > peak_held) peak_held = held;
            await_result(st, '0, 1'b1);
        endfunction

        function void flag(string what, iaid_pkg::t_result want, iaid_pkg::t_result got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%s: expected status=%0d data=%0d held=%0d last=%0d,", what,
                         want.status, want.data, want.held_count, want.last);
                $display("    got status=%0d data=%0d held=%0d last=%0d",
                         got.status, got.data, got.held_count, got.last);
            end
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check_word(iaid_pkg::t_result got);
            iaid_pkg::t_result want;
            results_checked++;
            if (awaited.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.held_count !== want.held_count || got.last !== want.last) begin
                flag("result mismatch", want, got);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void close_out();
            if (awaited.size() != 0) begin
                $display("%0d predicted results never arrived", awaited.size());
                mismatches += awaited.size();
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    iaid_pkg::t_in_item i_item;
    logic               empty;
    logic               pop;
    iaid_pkg::t_result  o_result;
    logic               hold_req;
    logic               hold_done;
    logic               quiet;

    array_mirror mirror = new();

    indexed_array_insert_delete #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_item(i_item),
        .empty(empty),
        .pop(pop),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) mirror.check_word(o_result);
    end

    // abort when nothing moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no word accepted for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // drain results with random stalls and one long hold-off
    initial begin
        int stall;
        stall     = 0;
        pop       = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (stall == 0 && !quiet && $urandom_range(9) == 0) begin
                stall = int'($urandom_range(1, 13));
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic iaid_pkg::t_in_item word_of(logic [iaid_pkg::MODE_W-1:0] mode,
                                                   logic [iaid_pkg::INDEX_W-1:0] index,
                                                   logic signed [iaid_pkg::WORD_W-1:0] value);
        iaid_pkg::t_in_item w;
        w.mode  = mode;
        w.index = index;
        w.value = value;
        return w;
    endfunction

    // random word whose operation mix follows the phase; indexes mostly in range
    function automatic iaid_pkg::t_in_item random_word(t_phase phase);
        iaid_pkg::t_in_item w;
        int                 r;
        int unsigned        h;
        h       = mirror.held;
        r       = int'($urandom_range(99));
        w.value = $urandom;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: w.value = 32'sh7FFFFFFF;
                1: w.value = 32'sh80000000;
                2: w.value = '0;
                default: w.value = '1;
            endcase
        end
        if (h > 0 && $urandom_range(9) != 0) begin
            w.index = iaid_pkg::INDEX_W'($urandom_range(h - 1));
        end else begin
            w.index = iaid_pkg::INDEX_W'($urandom_range(31));
        end
        if (r < 10) begin
            w.mode = iaid_pkg::MODE_FETCH;
        end else if (r < 12) begin
            w.mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
        end else begin
            case (phase)
                PH_GROW: begin
                    if (r < 56) w.mode = iaid_pkg::MODE_PUSH;
                    else if (r < 80) w.mode = iaid_pkg::MODE_INSERT;
                    else if (r < 88) w.mode = iaid_pkg::MODE_UPDATE;
                    else if (r < 94) w.mode = iaid_pkg::MODE_DELETE;
                    else w.mode = iaid_pkg::MODE_POP;
                end
                PH_SHRINK: begin
                    if (r < 24) w.mode = iaid_pkg::MODE_PUSH;
                    else if (r < 34) w.mode = iaid_pkg::MODE_INSERT;
                    else if (r < 50) w.mode = iaid_pkg::MODE_UPDATE;
                    else if (r < 76) w.mode = iaid_pkg::MODE_DELETE;
                    else w.mode = iaid_pkg::MODE_POP;
                end
                default: begin
                    if (r < 30) w.mode = iaid_pkg::MODE_PUSH;
                    else if (r < 47) w.mode = iaid_pkg::MODE_INSERT;
                    else if (r < 64) w.mode = iaid_pkg::MODE_UPDATE;
                    else if (r < 82) w.mode = iaid_pkg::MODE_DELETE;
                    else w.mode = iaid_pkg::MODE_POP;
                end
            endcase
        end
        return w;
    endfunction

    // offer one word from a falling edge and hold it until accepted
    task automatic send_word(iaid_pkg::t_in_item w);
        logic taken;
        push   <= 1'b1;
        i_item <= w;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !full;
            if (taken) mirror.note_word(w);
            @(negedge i_clk);
        end
    endtask

    // occasional idle burst on the input side
    task automatic sender_gap();
        int n;
        if (!quiet && !(hold_req && !hold_done) && $urandom_range(4) == 0) begin
            n = int'($urandom_range(1, 13));
            push <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // stop offering until every predicted result has come back
    task automatic wait_drained();
        push <= 1'b0;
        @(negedge i_clk);
        while (mirror.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        iaid_pkg::t_in_item directed[$];
        t_phase             phase;
        int                 phase_left;

        push     = 1'b0;
        i_item   = '0;
        i_rst_n  = 1'b0;
        hold_req = 1'b0;
        quiet    = 1'b0;
        phase      = PH_GROW;
        phase_left = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty array corner cases and ignored codes
        directed.push_back(word_of(iaid_pkg::MODE_FETCH, 5'd0, '0));
        directed.push_back(word_of(iaid_pkg::MODE_POP, 5'd0, '0));
        directed.push_back(word_of(iaid_pkg::MODE_INSERT, 5'd0, 32'sd5));
        directed.push_back(word_of(iaid_pkg::MODE_UPDATE, 5'd0, 32'sd6));
        directed.push_back(word_of(iaid_pkg::MODE_DELETE, 5'd31, '0));
        directed.push_back(word_of(MODE_SPARE_LO, 5'd31, '1));
        directed.push_back(word_of(MODE_SPARE_HI, 5'd0, 32'sh7FFFFFFF));
        // value extremes
        directed.push_back(word_of(iaid_pkg::MODE_PUSH, 5'd31, 32'sh7FFFFFFF));
        directed.push_back(word_of(iaid_pkg::MODE_PUSH, 5'd0, 32'sh80000000));
        directed.push_back(word_of(iaid_pkg::MODE_PUSH, 5'd0, '0));
        directed.push_back(word_of(iaid_pkg::MODE_PUSH, 5'd0, '1));
        // insert at the front, the last held slot, and out of range
        directed.push_back(word_of(iaid_pkg::MODE_INSERT, 5'd0, 32'sh12345678));
        directed.push_back(word_of(iaid_pkg::MODE_INSERT, 5'd4, 32'sh5A5A5A5A));
        directed.push_back(word_of(iaid_pkg::MODE_INSERT, 5'd6, 32'sd7));
        directed.push_back(word_of(iaid_pkg::MODE_INSERT, 5'd31, 32'sd8));
        directed.push_back(word_of(iaid_pkg::MODE_UPDATE, 5'd5, -32'sd2));
        directed.push_back(word_of(iaid_pkg::MODE_UPDATE, 5'd6, 32'sd9));
        directed.push_back(word_of(iaid_pkg::MODE_FETCH, 5'd31, '1));
        // delete front and back, then past the end
        directed.push_back(word_of(iaid_pkg::MODE_DELETE, 5'd0, '0));
        directed.push_back(word_of(iaid_pkg::MODE_DELETE, 5'd4, '0));
        directed.push_back(word_of(iaid_pkg::MODE_DELETE, 5'd4, '0));
        directed.push_back(word_of(iaid_pkg::MODE_POP, 5'd31, '1));
        directed.push_back(word_of(iaid_pkg::MODE_FETCH, 5'd0, '0));
        foreach (directed[i]) begin
            send_word(directed[i]);
            sender_gap();
        end

        // random phases that fill, churn and drain the array
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == HOLD_OFF_AT) hold_req = 1'b1;
            if (k == DRAIN_AT) wait_drained();
            if (k == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
            if (phase_left == 0) begin
                phase      = (k == 0) ? PH_GROW : t_phase'($urandom_range(2));
                phase_left = int'($urandom_range(40, 70));
            end
            phase_left--;
            send_word(random_word(phase));
            sender_gap();
        end

        // let the pipeline empty out
        push <= 1'b0;
        @(negedge i_clk);
        while (mirror.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        mirror.close_out();

        $display("Covered %0d input words (all six operations plus ignored codes),",
                 mirror.words_seen);
        $display("%0d results checked; array peaked at %0d of %0d words, %0d full rejections",
                 mirror.results_checked, mirror.peak_held, DEPTH, mirror.full_hits);
        if (mirror.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
